// ----- hdl/sab_pkg.sv -----
// ----------------------------------------------------------------------------
// sab_pkg: shared constants for the suffix automaton builder.
// Holds the default sizes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package sab_pkg;
    localparam int MAX_CHARS_DEF = 1024;
    localparam int ALPHABET_DEF  = 26;
    localparam int OUT_W         = 11;
    localparam int SYM_W         = 5;
endpackage
`default_nettype wire

// ----- hdl/suffix_automaton_builder_core.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_builder_core: online suffix automaton construction
//
// Input channel: i_valid/o_ready carries one symbol and a new_string flag.
// Output channel: o_valid/i_ready carries one result per request.
// Each request runs on a small sequencer around one transition memory port
// and one length/link memory port; every read is registered.
// An ordinary symbol walks suffix links from the last state, adding edges,
// until the walk runs past the root or stops on an existing edge. A clone
// then copies all transitions of the state it splits and redirects each
// edge that still points there. A dropped symbol skips the walk and goes to
// posting its result. o_ready rises as the result is posted, so the next
// request is taken in the following cycle at the earliest.
// The transition store is epoch tagged, so new_string only bumps the epoch.
// After reset, and on the new_string that wraps the 8-bit epoch, a clearing
// pass writes a zero tag into every transition word with o_ready low. A
// stalled result holds until i_ready while the next request is taken and
// processed; its result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_builder_core #(
    parameter int MAX_CHARS = sab_pkg::MAX_CHARS_DEF,
    parameter int ALPHABET  = sab_pkg::ALPHABET_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [sab_pkg::SYM_W-1:0]  i_symbol,
    input  wire logic                       i_new_string,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [sab_pkg::OUT_W-1:0]  o_new_state,
    output logic      [sab_pkg::OUT_W-1:0]  o_new_state_link,
    output logic      [sab_pkg::OUT_W-1:0]  o_state_total,
    output logic                            o_made_clone,
    output logic      [sab_pkg::OUT_W-1:0]  o_added_substrings,
    output logic                            o_full_res
);
    localparam int NST  = 2 * MAX_CHARS;
    localparam int SW   = $clog2(NST);
    localparam int CW   = $clog2(ALPHABET);
    localparam int TD   = NST * ALPHABET;
    localparam int TAW  = $clog2(TD);
    localparam int LW   = $clog2(MAX_CHARS + 1);
    localparam int EW   = 8;
    localparam int TW   = SW + EW;
    localparam int OW   = sab_pkg::OUT_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LEN_RD, S_LEN_WT, S_LEN_WR,
        S_E_RD, S_E_WT, S_E_CHK, S_LK_RD, S_LK_WT,
        S_V_RD, S_V_WT, S_V_CHK,
        S_CL_LK, S_CL_WR, S_CP_RD, S_CP_WT, S_CP_WR, S_V_LK,
        S_R_RD, S_R_WT, S_R_CHK, S_R_LK, S_R_LKQ, S_R_LKW,
        S_FIN_RD, S_FIN_WT, S_DONE
    } t_state;

    t_state r_st, r_resume;
    logic [SW-1:0]  r_last, r_used, r_fresh, r_u, r_v, r_clone, r_lnk;
    logic [LW-1:0]  r_taken;
    logic [CW-1:0]  r_c, r_k;
    logic [OW-1:0]  r_lenfresh, r_lenu;
    logic [EW-1:0]  r_epoch;
    logic [TAW-1:0] r_clr;
    logic           r_hit;

    // Length and link of v, captured before v's link is rewritten.
    logic [OW-1:0] r_vlen;
    logic [SW-1:0] r_vlink;

    // Result fields, moved to the output register once it is free.
    logic [OW-1:0] r_out_state, r_out_link, r_out_total, r_out_added;
    logic          r_out_clone, r_out_full;

    // Transition word: state index plus epoch of the owning state.
    logic           t_we;
    logic [TAW-1:0] t_addr;
    logic [TW-1:0]  t_wd, t_rd;
    // Length/link word: link plus length.
    logic           l_we;
    logic [SW-1:0]  l_addr;
    logic [SW+OW-1:0] l_wd, l_rd;

    sab_mem #(.DEPTH(TD), .W(TW)) u_trans (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wdata(t_wd), .o_rdata(t_rd));
    sab_mem #(.DEPTH(NST), .W(SW+OW)) u_node (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wd), .o_rdata(l_rd));

    logic [SW-1:0] t_tgt, l_link;
    logic [OW-1:0] l_len;
    logic          t_hit;
    assign t_tgt  = t_rd[SW-1:0];
    assign t_hit  = (t_rd[TW-1:SW] == r_epoch) && (t_tgt != '0);
    assign l_link = l_rd[SW+OW-1:OW];
    assign l_len  = l_rd[OW-1:0];

    function automatic logic [TAW-1:0] ta(input logic [SW-1:0] s, input logic [CW-1:0] c);
        return TAW'(s) * TAW'(ALPHABET) + TAW'(c);
    endfunction

    logic [TW-1:0] edge_fresh, edge_clone;
    assign edge_fresh = {r_epoch, r_fresh};
    assign edge_clone = {r_epoch, r_clone};

    // Counters and epoch as they stand once a new_string has taken effect.
    logic [SW-1:0] n_used;
    logic [LW-1:0] n_taken;
    logic [EW-1:0] n_epoch;
    logic          sym_full, sym_drop, out_free;

    always_comb begin
        n_used  = r_used;
        n_taken = r_taken;
        n_epoch = r_epoch;
        if (i_new_string) begin
            n_used  = '0;
            n_taken = '0;
            n_epoch = (r_epoch == '1) ? EW'(1) : r_epoch + EW'(1);
        end
        sym_full = (32'(n_taken) >= MAX_CHARS) || (32'(n_used) + 32'd2 >= NST);
        sym_drop = sym_full || (32'(i_symbol) >= ALPHABET);
    end

    assign out_free = !o_valid || i_ready;

    always_comb begin
        t_we = 1'b0; t_addr = ta(r_u, r_c); t_wd = edge_fresh;
        l_we = 1'b0; l_addr = r_u; l_wd = {r_lnk, r_lenfresh};
        unique case (r_st)
            S_CLEAR:  begin t_we = 1'b1; t_addr = r_clr; t_wd = '0; end
            S_LEN_RD: l_addr = r_last;
            S_LEN_WR: begin l_we = 1'b1; l_addr = r_fresh; l_wd = {SW'(0), r_lenfresh}; end
            S_E_CHK:  t_we = !t_hit;
            S_V_RD, S_V_WT: l_addr = r_v;
            S_CL_WR:  begin l_we = 1'b1; l_addr = r_clone; l_wd = {r_vlink, r_lenu + OW'(1)}; end
            S_CP_RD, S_CP_WT: t_addr = ta(r_v, r_k);
            S_CP_WR:  begin t_we = 1'b1; t_addr = ta(r_clone, r_k);
                            t_wd = t_hit ? t_rd : '0; end
            S_V_LK:   begin l_we = 1'b1; l_addr = r_v; l_wd = {r_clone, r_vlen}; end
            S_R_CHK:  begin t_we = t_hit && (t_tgt == r_v); t_wd = edge_clone; end
            S_FIN_RD, S_FIN_WT: l_addr = r_lnk;
            S_R_LKW:  begin l_we = 1'b1; l_addr = r_fresh; l_wd = {r_lnk, r_lenfresh}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_resume <= S_IDLE; r_clr <= '0;
            o_ready <= 1'b0; o_valid <= 1'b0;
            r_last <= '0; r_used <= '0; r_taken <= '0; r_epoch <= EW'(1);
        end else begin
            if (r_st == S_DONE && out_free) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;

            unique case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + TAW'(1);
                    if (r_clr == TAW'(TD - 1)) begin
                        r_st <= r_resume;
                        if (r_resume == S_IDLE) o_ready <= 1'b1;
                    end
                end
                S_IDLE: if (i_valid) begin
                    o_ready <= 1'b0;
                    r_epoch <= n_epoch;
                    r_c <= CW'(i_symbol);
                    r_out_state <= '0; r_out_link <= '0; r_out_clone <= 1'b0;
                    r_out_added <= '0; r_out_full <= sym_full;
                    r_out_total <= OW'(n_used);
                    r_lnk <= '0;
                    r_fresh <= n_used + SW'(1);
                    r_used <= sym_drop ? n_used : n_used + SW'(1);
                    r_taken <= sym_drop ? n_taken : n_taken + LW'(1);
                    if (i_new_string) r_last <= '0;
                    r_resume <= sym_drop ? S_DONE : S_LEN_RD;
                    // A wrapping epoch could revive stale edges, so the store
                    // is wiped before the request goes on.
                    if (i_new_string && r_epoch == '1) begin
                        r_clr <= '0; r_st <= S_CLEAR;
                    end else begin
                        r_st <= sym_drop ? S_DONE : S_LEN_RD;
                    end
                end
                S_LEN_RD: begin r_u <= r_last; r_st <= S_LEN_WT; end
                S_LEN_WT: begin
                    r_lenfresh <= (r_last == '0) ? OW'(1) : l_len + OW'(1);
                    r_st <= S_LEN_WR;
                end
                S_LEN_WR: r_st <= S_E_RD;
                S_E_RD: r_st <= S_E_WT;
                S_E_WT: r_st <= S_E_CHK;
                S_E_CHK: begin
                    r_hit <= t_hit;
                    if (t_hit) begin
                        r_v <= t_tgt; r_st <= S_LK_RD;
                    end else if (r_u == '0) begin
                        r_st <= S_R_LKW;
                    end else begin
                        r_st <= S_LK_RD;
                    end
                end
                // Read u's link and length. After a hit this serves to get len(u).
                S_LK_RD: r_st <= S_LK_WT;
                S_LK_WT: begin
                    if (r_hit) begin
                        r_lenu <= (r_u == '0) ? '0 : l_len; r_st <= S_V_RD;
                    end else begin
                        r_u <= l_link; r_st <= S_E_RD;
                    end
                end
                S_V_RD: r_st <= S_V_WT;
                S_V_WT: r_st <= S_V_CHK;
                S_V_CHK: begin
                    r_vlen <= l_len; r_vlink <= l_link;
                    if (l_len == r_lenu + OW'(1)) begin
                        r_lnk <= r_v; r_st <= S_R_LKW;
                    end else begin
                        r_clone <= r_used + SW'(1); r_used <= r_used + SW'(1);
                        r_st <= S_CL_LK;
                    end
                end
                S_CL_LK: r_st <= S_CL_WR;
                S_CL_WR: begin
                    r_lnk <= r_clone;
                    r_out_clone <= 1'b1; r_k <= '0; r_st <= S_CP_RD;
                end
                S_CP_RD: r_st <= S_CP_WT;
                S_CP_WT: r_st <= S_CP_WR;
                S_CP_WR: begin
                    r_k <= r_k + CW'(1);
                    r_st <= (32'(r_k) == ALPHABET - 1) ? S_V_LK : S_CP_RD;
                end
                S_V_LK: r_st <= S_R_RD;
                S_R_RD: r_st <= S_R_WT;
                S_R_WT: r_st <= S_R_CHK;
                S_R_CHK: begin
                    if (!(t_hit && (t_tgt == r_v)) || r_u == '0) r_st <= S_R_LKW;
                    else r_st <= S_R_LK;
                end
                S_R_LK: r_st <= S_R_LKQ;
                S_R_LKQ: begin r_u <= l_link; r_st <= S_R_RD; end
                S_R_LKW: begin r_last <= r_fresh; r_st <= S_FIN_RD; end
                S_FIN_RD: r_st <= S_FIN_WT;
                S_FIN_WT: begin
                    r_out_state <= OW'(r_fresh); r_out_link <= OW'(r_lnk);
                    r_out_total <= OW'(r_used);
                    r_out_added <= r_lenfresh - ((r_lnk == '0) ? OW'(0) : l_len);
                    r_st <= S_DONE;
                end
                S_DONE: if (out_free) begin
                    o_new_state <= r_out_state; o_new_state_link <= r_out_link;
                    o_state_total <= r_out_total; o_made_clone <= r_out_clone;
                    o_added_substrings <= r_out_added; o_full_res <= r_out_full;
                    o_ready <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/sab_mem.sv -----
// ----------------------------------------------------------------------------
// sab_mem: single port synchronous memory
// One write and one registered read per cycle at the same address; a write reads back the old word.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_mem #(
    parameter int DEPTH = 2048,
    parameter int W     = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [W-1:0]             i_wdata,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- tb/suffix_automaton_builder_core_test.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_builder_core_test: self-checking bench for the builder
// Streams strings of letters into the block and predicts every result with
// an in-bench automaton: new states, suffix links, clones, substring counts,
// out-of-range letters and the symbol limit. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_builder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYMBOL_LIMIT = sab_pkg::MAX_CHARS_DEF;
    localparam int LETTERS      = sab_pkg::ALPHABET_DEF;
    localparam int STATE_SLOTS  = 2 * SYMBOL_LIMIT;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [10:0] state_id;
        logic [10:0] link;
        logic [10:0] total;
        logic        clone;
        logic [10:0] added;
        logic        full;
    } t_sam_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [sab_pkg::SYM_W-1:0] i_symbol = '0;
    logic                     i_new_string = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [sab_pkg::OUT_W-1:0] o_new_state;
    logic [sab_pkg::OUT_W-1:0] o_new_state_link;
    logic [sab_pkg::OUT_W-1:0] o_state_total;
    logic                     o_made_clone;
    logic [sab_pkg::OUT_W-1:0] o_added_substrings;
    logic                     o_full_res;

    suffix_automaton_builder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_symbol(i_symbol), .i_new_string(i_new_string),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_new_state(o_new_state), .o_new_state_link(o_new_state_link),
        .o_state_total(o_state_total), .o_made_clone(o_made_clone),
        .o_added_substrings(o_added_substrings), .o_full_res(o_full_res)
    );

    // Shadow automaton.
    int unsigned edges [STATE_SLOTS*LETTERS];
    int unsigned links [STATE_SLOTS];
    int unsigned lengths [STATE_SLOTS];
    int unsigned tail_state, states_made, letters_taken;

    t_sam_result pending_results [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Only the states in use can hold edges, so only those are cleared.
    function automatic void clear_automaton();
        for (int s = 0; s <= states_made; s++) begin
            for (int c = 0; c < LETTERS; c++) edges[s*LETTERS+c] = 0;
            links[s] = 0;
            lengths[s] = 0;
        end
        tail_state = 0;
        states_made = 0;
        letters_taken = 0;
    endfunction

    function automatic t_sam_result extend_automaton(int unsigned sym, bit restart);
        t_sam_result r;
        int unsigned fresh, u, v, lnk, cl;
        bit past_root;
        r = '0;
        if (restart) clear_automaton();
        if (letters_taken >= SYMBOL_LIMIT || states_made + 2 >= STATE_SLOTS) begin
            r.total = 11'(states_made);
            r.full = 1'b1;
            return r;
        end
        if (sym >= LETTERS) begin
            r.total = 11'(states_made);
            return r;
        end
        letters_taken++;
        fresh = ++states_made;
        lengths[fresh] = lengths[tail_state] + 1;
        u = tail_state;
        lnk = 0;
        past_root = 1'b0;
        while (1) begin
            if (edges[u*LETTERS+sym] != 0) break;
            edges[u*LETTERS+sym] = fresh;
            if (u == 0) begin
                past_root = 1'b1;
                break;
            end
            u = links[u];
        end
        if (!past_root) begin
            v = edges[u*LETTERS+sym];
            if (lengths[v] == lengths[u] + 1) begin
                lnk = v;
            end else begin
                cl = ++states_made;
                r.clone = 1'b1;
                lengths[cl] = lengths[u] + 1;
                links[cl] = links[v];
                for (int c = 0; c < LETTERS; c++) edges[cl*LETTERS+c] = edges[v*LETTERS+c];
                links[v] = cl;
                lnk = cl;
                while (edges[u*LETTERS+sym] == v) begin
                    edges[u*LETTERS+sym] = cl;
                    if (u == 0) break;
                    u = links[u];
                end
            end
        end
        links[fresh] = lnk;
        tail_state = fresh;
        r.state_id = 11'(fresh);
        r.link = 11'(lnk);
        r.total = 11'(states_made);
        r.added = 11'(lengths[fresh] - lengths[lnk]);
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        mismatches++;
    endtask

    // Valid stays high after an accept; it is lowered by an idle cycle or by drain_results.
    task automatic send_symbol(int unsigned sym, bit restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= sym[4:0];
        i_new_string <= restart;
        pending_results.insert(pending_results.size(), extend_automaton(sym, restart));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sam_result want;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_new_state !== want.state_id)
                    report_mismatch("new_state", o_new_state, want.state_id);
                if (o_new_state_link !== want.link)
                    report_mismatch("new_state_link", o_new_state_link, want.link);
                if (o_state_total !== want.total)
                    report_mismatch("state_total", o_state_total, want.total);
                if (o_made_clone !== want.clone)
                    report_mismatch("made_clone", o_made_clone, want.clone);
                if (o_added_substrings !== want.added)
                    report_mismatch("added_substrings", o_added_substrings, want.added);
                if (o_full_res !== want.full)
                    report_mismatch("full_res", o_full_res, want.full);
            end
        end
    end

    task automatic test_directed();
        int unsigned word [8] = '{0, 1, 2, 1, 2, 0, 1, 2};
        send_symbol(0, 1'b1);
        send_symbol(25, 1'b0);
        send_symbol(26, 1'b0);
        send_symbol(31, 1'b0);
        // A repeated pair forces a clone.
        send_symbol(0, 1'b1);
        foreach (word[i]) send_symbol(word[i], 1'b0);
        for (int i = 0; i < 4; i++) send_symbol(3, i == 0);
        // The clear still happens when the letter itself is dropped.
        send_symbol(31, 1'b1);
        send_symbol(25, 1'b0);
        send_symbol(16, 1'b1);
        send_symbol(15, 1'b0);
    endtask

    task automatic test_random_strings(int unsigned count);
        int unsigned sent, len, span;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(60, 1);
            case ($urandom_range(3))
                0: span = 2;
                1: span = 3;
                2: span = 5;
                default: span = LETTERS;
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < 5)
                    send_symbol($urandom_range(31, LETTERS), i == 0);
                else
                    send_symbol($urandom_range(span - 1), i == 0);
                sent++;
            end
        end
    endtask

    task automatic test_symbol_limit();
        send_symbol($urandom_range(2), 1'b1);
        for (int i = 1; i < SYMBOL_LIMIT + 3; i++) send_symbol($urandom_range(2), 1'b0);
        send_symbol(31, 1'b0);
        send_symbol(4, 1'b1);
        send_symbol(4, 1'b0);
    endtask

    initial begin
        tail_state = 0;
        states_made = STATE_SLOTS - 1;
        clear_automaton();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 54;
        test_directed();
        test_random_strings(170);
        drain_results();

        send_idle_pct = 54;
        recv_idle_pct = 32;
        test_random_strings(170);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(170);
        test_symbol_limit();
        drain_results();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
